// File: hw/rtl/lbs_pkg.sv
// Shared constants, types and saturation helpers for the linear blend skinning block.
`timescale 1ns / 1ps

package lbs_pkg;

    localparam int MAX_JOINTS      = 64;
    localparam int WORDS_PER_JOINT = 12;
    localparam int ROWS_PER_JOINT  = 3;
    localparam int ROW_LANES       = 4;
    localparam int PAL_WORDS       = MAX_JOINTS * WORDS_PER_JOINT;
    localparam int PAL_ROWS        = MAX_JOINTS * ROWS_PER_JOINT;
    localparam int ROW_W           = $clog2(PAL_ROWS);

    localparam int VAL_W    = 32;
    localparam int ACC_W    = 48;
    localparam int WEIGHT_W = 17;
    localparam int JOINT_W  = 6;
    localparam int ADDR_W   = 10;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_INFL  = 2'd2
    } lbs_kind_t;

    localparam logic [1:0] SLOT_POS  = 2'd0;
    localparam logic [1:0] SLOT_NORM = 2'd1;
    localparam logic [1:0] SLOT_TAN  = 2'd2;
    localparam logic [1:0] LAST_ROW  = 2'(ROWS_PER_JOINT - 1);

    // One palette row: four Q16.16 words, column 0 in the low lane.
    typedef logic [ROW_LANES-1:0][VAL_W-1:0] lbs_row_t;
    // One vector: x in the low lane.
    typedef logic [2:0][VAL_W-1:0] lbs_triple_t;
    // Position, normal and tangent.
    typedef lbs_triple_t [2:0] lbs_vecs_t;

    typedef struct packed {
        logic       issue_valid;
        logic [1:0] issue_row;
        logic       clear;
        logic [1:0] emit_sel;
    } lbs_ctrl_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [49:0] x);
        logic signed [VAL_W-1:0] r;
        if (x[49:31] == {19{x[49]}}) begin
            r = x[31:0];
        end else if (x[49]) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W:0] x);
        logic signed [ACC_W-1:0] r;
        if (x[ACC_W] == x[ACC_W-1]) begin
            r = x[ACC_W-1:0];
        end else if (x[ACC_W]) begin
            r = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/lbs_palette_mem.sv
// Matrix palette memory: one 3x4 matrix row per entry, word-lane writes, registered row reads.
`timescale 1ns / 1ps

module lbs_palette_mem (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [lbs_pkg::ROW_W-1:0]  wr_row,
    input  logic [1:0]                 wr_lane,
    input  logic [lbs_pkg::VAL_W-1:0]  wr_data,
    input  logic                       rd_en,
    input  logic [lbs_pkg::ROW_W-1:0]  rd_row,
    output lbs_pkg::lbs_row_t          rd_data
);
    import lbs_pkg::*;

    lbs_row_t mem [PAL_ROWS];
    lbs_row_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][wr_lane] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/lbs_blend_datapath.sv
// Multiply-accumulate pipeline for one matrix row per cycle, plus the blend accumulators.
`timescale 1ns / 1ps

module lbs_blend_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lbs_pkg::lbs_ctrl_t            ctrl,
    input  lbs_pkg::lbs_row_t             row_data,
    input  lbs_pkg::lbs_vecs_t            vecs,
    input  logic [lbs_pkg::WEIGHT_W-1:0]  weight,
    output logic                          busy,
    output lbs_pkg::lbs_triple_t          emit_vec
);
    import lbs_pkg::*;

    // Stage A tracks the memory read latency.
    logic       a_valid_reg;
    logic [1:0] a_row_reg;
    // Stage B: the nine exact products of the row.
    logic              b_valid_reg;
    logic [1:0]        b_row_reg;
    logic signed [63:0] prod_reg [3][3];
    logic signed [VAL_W-1:0] trans_reg;
    // Stage C: saturated row sums per vector.
    logic              c_valid_reg;
    logic [1:0]        c_row_reg;
    logic signed [VAL_W-1:0] sum_reg [3];
    // Stage D: weighted sums.
    logic              d_valid_reg;
    logic [1:0]        d_row_reg;
    logic signed [49:0] wp_reg [3];

    logic signed [ACC_W-1:0] acc_reg [3][3];

    logic signed [49:0]      sum_next [3];
    logic signed [ACC_W-1:0] acc_next [3];

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            sum_next[v] = 50'($signed(prod_reg[v][0][63:16]))
                        + 50'($signed(prod_reg[v][1][63:16]))
                        + 50'($signed(prod_reg[v][2][63:16]));
            if (v == 0) begin
                sum_next[v] = sum_next[v] + 50'(trans_reg);
            end
        end
    end

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            acc_next[v] = sat48((ACC_W+1)'(acc_reg[v][d_row_reg])
                              + (ACC_W+1)'($signed(wp_reg[v][49:16])));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= ctrl.issue_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_row_reg <= ctrl.issue_row;
        b_row_reg <= a_row_reg;
        c_row_reg <= b_row_reg;
        d_row_reg <= c_row_reg;
        for (int v = 0; v < 3; v++) begin
            for (int c = 0; c < 3; c++) begin
                prod_reg[v][c] <= $signed(row_data[c]) * $signed(vecs[v][c]);
            end
            sum_reg[v] <= sat32(sum_next[v]);
            wp_reg[v]  <= sum_reg[v] * $signed({1'b0, weight});
        end
        trans_reg <= $signed(row_data[3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            for (int v = 0; v < 3; v++) begin
                for (int r = 0; r < 3; r++) begin
                    acc_reg[v][r] <= '0;
                end
            end
        end else if (d_valid_reg) begin
            for (int v = 0; v < 3; v++) begin
                acc_reg[v][d_row_reg] <= acc_next[v];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            emit_vec[r] = sat32(50'(acc_reg[ctrl.emit_sel][r]));
        end
    end

    assign busy = a_valid_reg | b_valid_reg | c_valid_reg | d_valid_reg;

endmodule

// File: hw/rtl/vertex_matrix_palette_skinning.sv
// Top level of the matrix palette skinning block: request decode, sequencing and result register.
// Palette writes, vector loads and zero-weight influences are handled in the idle state. A weighted
// influence reads three palette rows, then drains the multiply-accumulate pipeline (stages A to D)
// before the next request is taken. A last influence then loads its three results into the
// result register, one per cycle as the result side takes them. Synchronous reset clears the
// sequencing state, valid flags, loaded vectors and blend accumulators, but not the palette.
`timescale 1ns / 1ps

module vertex_matrix_palette_skinning (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // word_addr[9:0], word_value[41:10], in_x[73:42], in_y[105:74], in_z[137:106],
    // joint[143:138], weight[160:144], zero fill up to 167
    input  logic [167:0] s_tdata,
    // kind[1:0], vector_slot[3:2]
    input  logic [3:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  m_tdata,
    // out_slot[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);
    import lbs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [1:0]            row_reg;
    logic [1:0]            emit_cnt_reg;
    logic [JOINT_W-1:0]    joint_reg;
    logic [WEIGHT_W-1:0]   weight_reg;
    logic                  last_reg;
    lbs_vecs_t             vec_reg;
    logic                  m_tvalid_reg;
    logic [1:0]            out_slot_reg;
    lbs_triple_t           out_vec_reg;
    logic                  out_last_reg;

    logic [ADDR_W-1:0]     in_addr;
    logic [VAL_W-1:0]      in_value;
    lbs_triple_t           in_vec;
    logic [JOINT_W-1:0]    in_joint;
    logic [WEIGHT_W-1:0]   in_weight;
    lbs_kind_t             in_kind;
    logic [1:0]            in_slot;

    logic                  accept;
    logic                  pal_wr_en;
    logic                  emit_load;
    logic                  dp_busy;
    lbs_ctrl_t             ctrl;
    lbs_row_t              row_data;
    lbs_triple_t           emit_vec;
    logic [ROW_W-1:0]      rd_row;

    assign in_addr   = s_tdata[9:0];
    assign in_value  = s_tdata[41:10];
    assign in_vec    = s_tdata[137:42];
    assign in_joint  = s_tdata[143:138];
    assign in_weight = s_tdata[160:144];
    assign in_kind   = lbs_kind_t'(s_tuser[1:0]);
    assign in_slot   = s_tuser[3:2];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign pal_wr_en = accept && (in_kind == KIND_WRITE) && (int'(in_addr) < PAL_WORDS);
    assign emit_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    assign rd_row = ROW_W'(int'(joint_reg) * ROWS_PER_JOINT + int'(row_reg));

    always_comb begin
        ctrl.issue_valid = (state_reg == ST_ISSUE);
        ctrl.issue_row   = row_reg;
        ctrl.clear       = emit_load && (emit_cnt_reg == SLOT_TAN);
        ctrl.emit_sel    = emit_cnt_reg;
    end

    lbs_palette_mem u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr_en),
        .wr_row  (ROW_W'(in_addr >> 2)),
        .wr_lane (in_addr[1:0]),
        .wr_data (in_value),
        .rd_en   (ctrl.issue_valid),
        .rd_row  (rd_row),
        .rd_data (row_data)
    );

    lbs_blend_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .row_data (row_data),
        .vecs     (vec_reg),
        .weight   (weight_reg),
        .busy     (dp_busy),
        .emit_vec (emit_vec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            emit_cnt_reg <= '0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            vec_reg      <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && !emit_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (in_kind)
                            KIND_WRITE: begin
                                // The palette write happens in the memory.
                            end
                            KIND_LOAD: begin
                                if (in_slot != 2'd3) begin
                                    vec_reg[in_slot] <= in_vec;
                                end
                            end
                            KIND_INFL: begin
                                joint_reg    <= in_joint;
                                weight_reg   <= in_weight;
                                last_reg     <= s_tlast;
                                row_reg      <= '0;
                                emit_cnt_reg <= SLOT_POS;
                                if (in_weight != '0 && int'(in_joint) < MAX_JOINTS) begin
                                    state_reg <= ST_ISSUE;
                                end else if (s_tlast) begin
                                    state_reg <= ST_EMIT;
                                end
                            end
                            default: begin
                                // Reserved kind: dropped.
                            end
                        endcase
                    end
                end
                ST_ISSUE: begin
                    row_reg <= row_reg + 2'd1;
                    if (row_reg == LAST_ROW) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!dp_busy) begin
                        state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        m_tvalid_reg <= 1'b1;
                        out_slot_reg <= emit_cnt_reg;
                        out_vec_reg  <= emit_vec;
                        out_last_reg <= (emit_cnt_reg == SLOT_TAN);
                        emit_cnt_reg <= emit_cnt_reg + 2'd1;
                        if (emit_cnt_reg == SLOT_TAN) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_vec_reg;
    assign m_tuser  = out_slot_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: verif/vertex_matrix_palette_skinning_tb.sv
// Self-checking testbench for the matrix palette skinning block, with a built-in predictor.
`timescale 1ns / 1ps

module vertex_matrix_palette_skinning_tb;
    import lbs_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] SLOT_UNUSED = 2'd3;
    localparam int ITEM_TARGET   = 330;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 40;
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint S32_MIN   = -64'sd2147483648;
    localparam longint ACC_MAX   = 64'sd140737488355327;
    localparam longint ACC_MIN   = -64'sd140737488355328;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    typedef struct {
        logic [1:0]  kind;
        logic [9:0]  word_addr;
        logic [31:0] word_value;
        logic [1:0]  slot;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [5:0]  joint;
        logic [16:0] weight;
        logic        last_mark;
    } skin_req_t;

    typedef struct {
        logic [1:0]  slot;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        is_last;
    } skin_out_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // word_addr, word_value, in_x, in_y, in_z, joint, weight, zero fill
    logic [167:0] s_tdata;
    // kind, vector_slot
    logic [3:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    // out_x, out_y, out_z
    logic [95:0]  m_tdata;
    // out_slot
    logic [1:0]   m_tuser;
    logic         m_tlast;

    vertex_matrix_palette_skinning u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Predicted state of the block.
    logic signed [31:0] pal_word  [PAL_WORDS];
    bit                 pal_known [PAL_WORDS];
    logic signed [31:0] vec_word  [9];
    longint             blend_acc [9];
    skin_out_t          skinned_q [$];

    int  mismatch_count = 0;
    int  applied_count  = 0;
    bit  tx_idle_en     = 1'b1;
    bit  rx_idle_en     = 1'b1;
    bit  hold_req       = 1'b0;
    skin_out_t got_res;
    skin_out_t want_res;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic longint clamp_s32(longint x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic bit joint_ready(int j);
        for (int e = 0; e < WORDS_PER_JOINT; e++) begin
            if (!pal_known[j * WORDS_PER_JOINT + e]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pick_ready_joint();
        int ready [$];
        for (int j = 0; j < MAX_JOINTS; j++) begin
            if (joint_ready(j)) ready.push_back(j);
        end
        return ready[$urandom_range(0, ready.size() - 1)];
    endfunction

    // Mostly short gaps, now and then a long one; never zero.
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            1, 2: v = $urandom;
            default: v = 32'($urandom_range(0, 33554431)) - 32'd16777216;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_elem();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return 32'($urandom_range(0, 262143)) - 32'd131072;
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'($urandom_range(65537, 131071));
            2: return 17'd65536;
            default: return 17'($urandom_range(1, 65535));
        endcase
    endfunction

    // Fields that the kind does not use carry random junk.
    function automatic skin_req_t junk_req();
        skin_req_t r;
        r.kind       = 2'($urandom);
        r.word_addr  = 10'($urandom);
        r.word_value = $urandom;
        r.slot       = 2'($urandom);
        r.vx         = $urandom;
        r.vy         = $urandom;
        r.vz         = $urandom;
        r.joint      = 6'($urandom);
        r.weight     = 17'($urandom);
        r.last_mark  = 1'b0;
        return r;
    endfunction

    function automatic skin_req_t word_req(logic [9:0] addr, logic [31:0] value);
        skin_req_t r;
        r = junk_req();
        r.kind       = KIND_WRITE;
        r.word_addr  = addr;
        r.word_value = value;
        return r;
    endfunction

    function automatic skin_req_t vector_req(logic [1:0] slot, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z);
        skin_req_t r;
        r = junk_req();
        r.kind = KIND_LOAD;
        r.slot = slot;
        r.vx   = x;
        r.vy   = y;
        r.vz   = z;
        return r;
    endfunction

    function automatic skin_req_t infl_req(logic [5:0] joint, logic [16:0] weight,
                                           logic last_mark);
        skin_req_t r;
        r = junk_req();
        r.kind      = KIND_INFL;
        r.joint     = joint;
        r.weight    = weight;
        r.last_mark = last_mark;
        return r;
    endfunction

    // Adds weight * (M * v) for all three vectors; only the position takes the translation.
    task automatic blend_joint(int base, longint w);
        int     v, r, c;
        longint sum, prod, acc;
        for (v = 0; v < 3; v++) begin
            for (r = 0; r < 3; r++) begin
                sum = 0;
                for (c = 0; c < 3; c++) begin
                    prod = longint'(pal_word[base + r * 4 + c]) * longint'(vec_word[v * 3 + c]);
                    sum += prod >>> 16;
                end
                if (v == 0) sum += longint'(pal_word[base + r * 4 + 3]);
                sum = clamp_s32(sum);
                acc = blend_acc[v * 3 + r] + ((sum * w) >>> 16);
                if (acc > ACC_MAX) acc = ACC_MAX;
                if (acc < ACC_MIN) acc = ACC_MIN;
                blend_acc[v * 3 + r] = acc;
            end
        end
    endtask

    task automatic predict_skin(skin_req_t r);
        skin_out_t o;
        longint    w, t;
        int        k;
        case (r.kind)
            KIND_WRITE: begin
                if (r.word_addr < PAL_WORDS) begin
                    pal_word[r.word_addr]  = r.word_value;
                    pal_known[r.word_addr] = 1'b1;
                    applied_count++;
                end
            end
            KIND_LOAD: begin
                if (r.slot != SLOT_UNUSED) begin
                    vec_word[r.slot * 3 + 0] = r.vx;
                    vec_word[r.slot * 3 + 1] = r.vy;
                    vec_word[r.slot * 3 + 2] = r.vz;
                    applied_count++;
                end
            end
            KIND_INFL: begin
                applied_count++;
                w = r.weight;
                if (w != 0 && r.joint < MAX_JOINTS) blend_joint(r.joint * WORDS_PER_JOINT, w);
                if (r.last_mark) begin
                    for (k = 0; k < 3; k++) begin
                        o.slot    = 2'(k);
                        t         = clamp_s32(blend_acc[k * 3 + 0]);
                        o.x       = t[31:0];
                        t         = clamp_s32(blend_acc[k * 3 + 1]);
                        o.y       = t[31:0];
                        t         = clamp_s32(blend_acc[k * 3 + 2]);
                        o.z       = t[31:0];
                        o.is_last = (k == 2);
                        skinned_q.push_back(o);
                    end
                    for (k = 0; k < 9; k++) blend_acc[k] = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_req(skin_req_t r);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 2) == 0) gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.weight, r.joint, r.vz, r.vy, r.vx, r.word_value, r.word_addr};
        s_tuser  <= {r.slot, r.kind};
        s_tlast  <= r.last_mark;
        do @(posedge aclk); while (!s_tready);
        predict_skin(r);
    endtask

    task automatic write_joint(int j, bit random_fill);
        logic [31:0] value;
        for (int e = 0; e < WORDS_PER_JOINT; e++) begin
            value = random_fill ? rand_elem() : 32'h0;
            send_req(word_req(10'(j * WORDS_PER_JOINT + e), value));
        end
    endtask

    task automatic send_vertex(int n_loads, int n_infl);
        logic [16:0] w;
        for (int i = 0; i < n_loads; i++) begin
            send_req(vector_req(2'($urandom_range(0, 2)), rand_coord(), rand_coord(),
                                rand_coord()));
        end
        for (int i = 0; i < n_infl; i++) begin
            w = rand_weight();
            send_req(infl_req(6'(w != 0 ? pick_ready_joint() : $urandom_range(0, 63)), w,
                              i == n_infl - 1));
        end
    endtask

    // Joint 0 is identity plus a translation, joint 63 sits at the extremes, joint 1 is random.
    task automatic test_palette_setup();
        logic [31:0] value;
        for (int e = 0; e < WORDS_PER_JOINT; e++) begin
            case (e)
                0, 5, 10: value = Q_ONE;
                3:        value = 32'h0002_0000;
                7:        value = 32'hFFFC_8000;
                11:       value = 32'h0000_8000;
                default:  value = 32'h0;
            endcase
            send_req(word_req(10'(e), value));
        end
        write_joint(1, 1'b1);
        for (int e = 0; e < WORDS_PER_JOINT; e++) begin
            case (e / 4)
                0:       value = 32'h7FFF_FFFF;
                1:       value = 32'h8000_0000;
                default: value = e[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            endcase
            send_req(word_req(10'(63 * WORDS_PER_JOINT + e), value));
        end
    endtask

    task automatic test_directed_cases();
        skin_req_t r;
        send_req(vector_req(SLOT_POS, 32'h0001_8000, 32'hFFFD_C000, 32'h0064_0000));
        send_req(vector_req(SLOT_NORM, 32'h0, Q_ONE, 32'h0));
        send_req(vector_req(SLOT_TAN, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        send_req(infl_req(6'd0, 17'd65536, 1'b1));
        // Weight above one on the extreme joint saturates; a zero weight still emits.
        send_req(infl_req(6'd63, 17'h1FFFF, 1'b0));
        send_req(infl_req(6'd1, 17'd0, 1'b1));
        // A zero weight on a joint never written reads nothing.
        send_req(infl_req(6'd5, 17'd0, 1'b1));
        r = junk_req();
        r.kind      = KIND_UNUSED;
        r.last_mark = 1'b1;
        send_req(r);
        send_req(vector_req(SLOT_UNUSED, $urandom, $urandom, $urandom));
        r = word_req(10'h3FF, $urandom);
        r.last_mark = 1'b1;
        send_req(r);
        r = word_req(10'(PAL_WORDS), $urandom);
        r.last_mark = 1'b1;
        send_req(r);
        r = word_req(10'd3, 32'hFFFF_0000);
        r.last_mark = 1'b1;
        send_req(r);
        r = vector_req(SLOT_POS, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        r.last_mark = 1'b1;
        send_req(r);
        send_req(infl_req(6'd0, 17'd32768, 1'b0));
        send_req(infl_req(6'd1, 17'd65535, 1'b0));
        send_req(infl_req(6'd63, 17'd1, 1'b1));
        // The vectors stay loaded after a vertex is emitted.
        send_req(infl_req(6'd0, 17'd65536, 1'b1));
    endtask

    // The result side holds off while vertices keep coming, so the block must stall its input.
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (6) send_vertex(3, 1);
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_vertices();
        skin_req_t r;
        while (applied_count < ITEM_TARGET) begin
            case ($urandom_range(0, 11))
                0: begin
                    case ($urandom_range(0, 3))
                        0: begin
                            r = word_req(10'($urandom_range(0, 1023)), $urandom);
                            r.last_mark = 1'($urandom);
                        end
                        1: begin
                            r = junk_req();
                            r.kind      = KIND_UNUSED;
                            r.last_mark = 1'($urandom);
                        end
                        2: r = vector_req(SLOT_UNUSED, $urandom, $urandom, $urandom);
                        default: begin
                            r = vector_req(2'($urandom_range(0, 2)), rand_coord(), rand_coord(),
                                           rand_coord());
                            r.last_mark = 1'b1;
                        end
                    endcase
                    send_req(r);
                end
                1: write_joint($urandom_range(0, MAX_JOINTS - 1), 1'b1);
                2: begin
                    tx_idle_en = 1'($urandom);
                    rx_idle_en = 1'($urandom);
                end
                default: send_vertex($urandom_range(0, 3), $urandom_range(1, 4));
            endcase
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < PAL_WORDS; i++) begin
            pal_word[i]  = '0;
            pal_known[i] = 1'b0;
        end
        for (int i = 0; i < 9; i++) begin
            vec_word[i]  = '0;
            blend_acc[i] = 0;
        end
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_palette_setup();
        test_directed_cases();
        test_backpressure();
        test_random_vertices();
        s_tvalid <= 1'b0;

        while (skinned_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when requested.
    initial begin
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res.slot    = m_tuser;
            got_res.x       = m_tdata[31:0];
            got_res.y       = m_tdata[63:32];
            got_res.z       = m_tdata[95:64];
            got_res.is_last = m_tlast;
            if (skinned_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected skinned result: slot %0d xyz %h %h %h last %0b",
                         $time, got_res.slot, got_res.x, got_res.y, got_res.z, got_res.is_last);
            end else begin
                want_res = skinned_q.pop_front();
                if (got_res.slot !== want_res.slot || got_res.x !== want_res.x ||
                    got_res.y !== want_res.y || got_res.z !== want_res.z ||
                    got_res.is_last !== want_res.is_last) begin
                    mismatch_count++;
                    $display("%0t: skinned result mismatch: expected slot %0d xyz %h %h %h ",
                             $time, want_res.slot, want_res.x, want_res.y, want_res.z,
                             "last %0b, got slot %0d xyz %h %h %h last %0b",
                             want_res.is_last, got_res.slot, got_res.x, got_res.y, got_res.z,
                             got_res.is_last);
                end
            end
        end
    end

    // Ends the run when neither side has moved a request for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_palette_mem.sv
hw/rtl/lbs_blend_datapath.sv
hw/rtl/vertex_matrix_palette_skinning.sv
verif/vertex_matrix_palette_skinning_tb.sv
